// File: rtl/pid_position_controller_macros.svh
// Assertion macros for the file that carries concurrent checks.
// Every macro samples on clk and is quiet while rst_n is low.
`ifndef PID_POSITION_CONTROLLER_MACROS_SVH
`define PID_POSITION_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDPC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/pidpc_pkg.sv
`timescale 1ns / 1ps

package pidpc_pkg;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_KP       = 3'd0;
  localparam cfg_idx_t REG_KI_DT    = 3'd1;
  localparam cfg_idx_t REG_KD_DT    = 3'd2;
  localparam cfg_idx_t REG_DEADBAND = 3'd3;
  localparam cfg_idx_t REG_ILIMITS  = 3'd4;
  localparam cfg_idx_t REG_OLIMITS  = 3'd5;
  localparam cfg_idx_t REG_DLIMIT   = 3'd6;

  localparam int CFG_DW  = 32;
  localparam int GAIN_W  = 24;
  localparam int DB_W    = 16;
  localparam int LIM_W   = 16;
  localparam int DLIM_W  = 15;
  localparam int DRIVE_W = 16;

  // Limit pair in integer units, always held with lo <= hi.
  typedef struct packed {
    logic signed [LIM_W-1:0] lo;
    logic signed [LIM_W-1:0] hi;
  } lim_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki_dt;
    logic signed [GAIN_W-1:0] kd_dt;
    logic        [DB_W-1:0]   deadband;
    lim_t                     ilim;
    lim_t                     olim;
    logic        [DLIM_W-1:0] d_limit;
  } cfg_t;

  localparam lim_t LIM_RESET = '{lo: 16'sh8000, hi: 16'sh7FFF};

  // Splits a written limit word into its pair and puts a reversed pair in order.
  function automatic lim_t lim_decode(input logic [CFG_DW-1:0] word);
    logic signed [LIM_W-1:0] a;
    logic signed [LIM_W-1:0] b;
    lim_t                    res;
    a = $signed(word[LIM_W-1:0]);
    b = $signed(word[2*LIM_W-1:LIM_W]);
    if (a > b) begin
      res.lo = b;
      res.hi = a;
    end else begin
      res.lo = a;
      res.hi = b;
    end
    return res;
  endfunction

endpackage

// File: rtl/pidpc_front.sv
`timescale 1ns / 1ps

module pidpc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            load,
  input  logic                                            restart,
  input  logic signed [SAMPLE_BITS-1:0]                   setpoint,
  input  logic signed [SAMPLE_BITS-1:0]                   measurement,
  input  pidpc_pkg::cfg_t                                 cfg,
  output logic                                            restart_r,
  output logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0]   p_prod_r,
  output logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0]   i_prod_r,
  output logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0]   d_prod_r
);

  localparam int EW = SAMPLE_BITS + 1;
  localparam int PW = pidpc_pkg::GAIN_W + EW;
  localparam int CW = (EW > pidpc_pkg::DB_W) ? EW : pidpc_pkg::DB_W;

  logic                          have_prev_r;
  logic signed [SAMPLE_BITS-1:0] prev_meas_r;

  logic signed [EW-1:0]          err;
  logic        [EW-1:0]          mag;
  logic signed [EW-1:0]          err_db;
  logic signed [SAMPLE_BITS-1:0] prev_eff;
  logic signed [EW-1:0]          diff;
  logic signed [PW-1:0]          p_prod;
  logic signed [PW-1:0]          i_prod;
  logic signed [PW-1:0]          d_prod;

  assign err = EW'(setpoint) - EW'(measurement);
  assign mag = err[EW-1] ? EW'(-err) : EW'(err);

  always_comb begin
    err_db = err;
    if ((cfg.deadband != '0) && (CW'(mag) < CW'(cfg.deadband))) begin
      err_db = '0;
    end
  end

  // With no earlier measurement the current one stands in, so the change is zero.
  assign prev_eff = have_prev_r ? prev_meas_r : measurement;
  assign diff     = EW'(measurement) - EW'(prev_eff);

  assign p_prod = cfg.kp * err_db;
  assign i_prod = cfg.ki_dt * err_db;
  assign d_prod = cfg.kd_dt * diff;

  // Both kinds of request leave the measurement behind as the previous one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_meas_r <= '0;
    end else if (load) begin
      have_prev_r <= 1'b1;
      prev_meas_r <= measurement;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      restart_r <= restart;
      p_prod_r  <= p_prod;
      i_prod_r  <= i_prod;
      d_prod_r  <= d_prod;
    end
  end

endmodule

// File: rtl/pidpc_back.sv
`timescale 1ns / 1ps

module pidpc_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          load,
  input  logic                                          restart,
  input  logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0] p_prod,
  input  logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0] i_prod,
  input  logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0] d_prod,
  input  pidpc_pkg::cfg_t                               cfg,
  output logic signed [pidpc_pkg::DRIVE_W-1:0]          drive_r
);

  localparam int PW = pidpc_pkg::GAIN_W + SAMPLE_BITS + 1;
  localparam int IW = pidpc_pkg::LIM_W + FRAC_BITS;
  localparam int W  = ((PW > IW) ? PW : IW) + 3;

  logic signed [IW-1:0] integ_r;
  logic signed [IW-1:0] integ_nxt;

  logic signed [W-1:0] ilo, ihi, olo, ohi, dlim;
  logic signed [W-1:0] isum, inew, dneg, dcl, tot, tcl;

  assign ilo  = W'($signed({cfg.ilim.lo, {FRAC_BITS{1'b0}}}));
  assign ihi  = W'($signed({cfg.ilim.hi, {FRAC_BITS{1'b0}}}));
  assign olo  = W'($signed({cfg.olim.lo, {FRAC_BITS{1'b0}}}));
  assign ohi  = W'($signed({cfg.olim.hi, {FRAC_BITS{1'b0}}}));
  assign dlim = W'($signed({1'b0, cfg.d_limit, {FRAC_BITS{1'b0}}}));

  assign isum = W'(integ_r) + W'(i_prod);
  assign inew = (isum < ilo) ? ilo : ((isum > ihi) ? ihi : isum);

  assign dneg = -W'(d_prod);

  always_comb begin
    dcl = dneg;
    if (cfg.d_limit != '0) begin
      if (dneg < -dlim) begin
        dcl = -dlim;
      end else if (dneg > dlim) begin
        dcl = dlim;
      end
    end
  end

  assign tot = W'(p_prod) + inew + dcl;
  assign tcl = (tot < olo) ? olo : ((tot > ohi) ? ohi : tot);

  // The clamped integrator always fits the limit range, so the narrowing is lossless.
  assign integ_nxt = restart ? '0 : $signed(inew[IW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (load) begin
      integ_r <= integ_nxt;
    end
  end

  // An arithmetic shift of the clamped sum gives the floored integer part.
  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= restart ? '0 : $signed(tcl[FRAC_BITS +: pidpc_pkg::DRIVE_W]);
    end
  end

endmodule

// File: rtl/pid_position_controller.sv
`timescale 1ns / 1ps
// A request taken on in_fire has its products registered in the first stage; the drive
// is registered in the second stage when the result register is empty or being taken.
// One request per cycle while out_tready holds; the multipliers sit in the first stage and the
// integrator add and clamp close their loop within the second stage.
// Reset (synchronous, rst_n low) clears the configuration to its defaults, the integrator,
// the measurement history and both stage valids.

`include "pid_position_controller_macros.svh"

module pid_position_controller #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,  // setpoint, measurement
  input  logic                                   in_tuser,  // req_type
  // Result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [pidpc_pkg::DRIVE_W-1:0]          out_tdata, // drive
  // Configuration writes
  input  logic                                   cfg_wen,
  input  pidpc_pkg::cfg_idx_t                    cfg_index,
  input  logic [pidpc_pkg::CFG_DW-1:0]           cfg_wdata
);

  localparam int PW = pidpc_pkg::GAIN_W + SAMPLE_BITS + 1;

  pidpc_pkg::cfg_t cfg_r;

  logic s1_valid_r;
  logic out_valid_r;
  logic in_fire;
  logic s2_load;

  logic                                  s1_restart;
  logic signed [PW-1:0]                  p_prod, i_prod, d_prod;
  logic signed [pidpc_pkg::DRIVE_W-1:0]  drive;

  // Configuration registers; limit pairs are stored already in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp       <= '0;
      cfg_r.ki_dt    <= '0;
      cfg_r.kd_dt    <= '0;
      cfg_r.deadband <= '0;
      cfg_r.ilim     <= pidpc_pkg::LIM_RESET;
      cfg_r.olim     <= pidpc_pkg::LIM_RESET;
      cfg_r.d_limit  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pidpc_pkg::REG_KP:       cfg_r.kp       <= $signed(cfg_wdata[pidpc_pkg::GAIN_W-1:0]);
        pidpc_pkg::REG_KI_DT:    cfg_r.ki_dt    <= $signed(cfg_wdata[pidpc_pkg::GAIN_W-1:0]);
        pidpc_pkg::REG_KD_DT:    cfg_r.kd_dt    <= $signed(cfg_wdata[pidpc_pkg::GAIN_W-1:0]);
        pidpc_pkg::REG_DEADBAND: cfg_r.deadband <= cfg_wdata[pidpc_pkg::DB_W-1:0];
        pidpc_pkg::REG_ILIMITS:  cfg_r.ilim     <= pidpc_pkg::lim_decode(cfg_wdata);
        pidpc_pkg::REG_OLIMITS:  cfg_r.olim     <= pidpc_pkg::lim_decode(cfg_wdata);
        pidpc_pkg::REG_DLIMIT:   cfg_r.d_limit  <= cfg_wdata[pidpc_pkg::DLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The result register loads from a full first stage whenever it is empty or being taken,
  // and the first stage refills behind it in the same cycle.
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  pidpc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .restart    (in_tuser),
    .setpoint   ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .measurement($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .cfg        (cfg_r),
    .restart_r  (s1_restart),
    .p_prod_r   (p_prod),
    .i_prod_r   (i_prod),
    .d_prod_r   (d_prod)
  );

  pidpc_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s2_load),
    .restart(s1_restart),
    .p_prod (p_prod),
    .i_prod (i_prod),
    .d_prod (d_prod),
    .cfg    (cfg_r),
    .drive_r(drive)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive;

  `PIDPC_ASSERT_NEXT(a_restart_zero, s2_load && s1_restart, out_tdata == '0, "restart request gave a nonzero drive")
  `PIDPC_ASSERT_NOW(a_ready_blocked, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled without a full pipeline")
  `PIDPC_ASSERT_NOW(a_out_source, $rose(out_tvalid), $past(s1_valid_r), "result appeared without a request in the first stage")

endmodule
